@@ sv/bsb_pkg.sv @@
// Shared constants for the box shape bounds pipeline.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package bsb_pkg;

	// default field widths
	localparam int COORD_WIDTH_DEF = 32;
	localparam int QUAT_WIDTH_DEF  = 16;

	// squared quaternion length at or below 2^(2F) / LEN_SQ_DIV counts as zero
	localparam longint unsigned LEN_SQ_DIV = 64'd100000;

	// shape kinds carried in tuser
	typedef enum logic {
		OP_AABB = 1'b0,
		OP_OBB  = 1'b1
	} op_t;

	// matrix lanes, row-major
	localparam int LANES = 9;

endpackage

@@ sv/bsb_quat.sv @@
// Quaternion front end: products, squared length and unnormalized rotation matrix.
// Two register stages. Depends on bsb_pkg.
`timescale 1ns / 1ps

module bsb_quat #(
	parameter int QUAT_WIDTH = bsb_pkg::QUAT_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         valid,
	input  logic signed [QUAT_WIDTH-1:0] qx,
	input  logic signed [QUAT_WIDTH-1:0] qy,
	input  logic signed [QUAT_WIDTH-1:0] qz,
	input  logic signed [QUAT_WIDTH-1:0] qw,
	output logic                         valid_s2,
	output logic [2*QUAT_WIDTH:0]        n_s2,
	output logic [2*QUAT_WIDTH:0]        mabs_s2 [bsb_pkg::LANES],
	output logic                         small_s2
);

	localparam int F  = QUAT_WIDTH - 2;
	localparam int PW = 2 * QUAT_WIDTH;
	localparam int NW = 2 * QUAT_WIDTH + 1;
	localparam int MW = 2 * QUAT_WIDTH + 2;
	localparam longint unsigned SMALL_L = (64'd1 << (2 * F)) / bsb_pkg::LEN_SQ_DIV;
	localparam logic [NW-1:0] SMALL_LEN_SQ = SMALL_L[NW-1:0];

	logic signed [PW-1:0] xx_s1, yy_s1, zz_s1, ww_s1;
	logic signed [PW-1:0] xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic                 valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1 <= qx * qx;
			yy_s1 <= qy * qy;
			zz_s1 <= qz * qz;
			ww_s1 <= qw * qw;
			xy_s1 <= qx * qy;
			xz_s1 <= qx * qz;
			yz_s1 <= qy * qz;
			wx_s1 <= qw * qx;
			wy_s1 <= qw * qy;
			wz_s1 <= qw * qz;
		end
	end

	logic signed [MW-1:0] m_c [bsb_pkg::LANES];
	logic        [NW-1:0] n_c;

	always_comb begin
		n_c = NW'($unsigned(xx_s1)) + NW'($unsigned(yy_s1))
			+ NW'($unsigned(zz_s1)) + NW'($unsigned(ww_s1));
		m_c[0] = MW'(ww_s1) + MW'(xx_s1) - MW'(yy_s1) - MW'(zz_s1);
		m_c[1] = (MW'(xy_s1) - MW'(wz_s1)) <<< 1;
		m_c[2] = (MW'(xz_s1) + MW'(wy_s1)) <<< 1;
		m_c[3] = (MW'(xy_s1) + MW'(wz_s1)) <<< 1;
		m_c[4] = MW'(ww_s1) - MW'(xx_s1) + MW'(yy_s1) - MW'(zz_s1);
		m_c[5] = (MW'(yz_s1) - MW'(wx_s1)) <<< 1;
		m_c[6] = (MW'(xz_s1) - MW'(wy_s1)) <<< 1;
		m_c[7] = (MW'(yz_s1) + MW'(wx_s1)) <<< 1;
		m_c[8] = MW'(ww_s1) - MW'(xx_s1) - MW'(yy_s1) + MW'(zz_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s2     <= n_c;
			small_s2 <= (n_c <= SMALL_LEN_SQ);
			for (int i = 0; i < bsb_pkg::LANES; i++) begin
				mabs_s2[i] <= m_c[i][MW-1] ? NW'(-m_c[i]) : NW'(m_c[i]);
			end
		end
	end

endmodule

@@ sv/bsb_div.sv @@
// Pipelined restoring divider for the nine matrix entries, one quotient bit per stage.
// Gives round(|m| * 2^F / n). Depends on bsb_pkg.
`timescale 1ns / 1ps

module bsb_div #(
	parameter int QUAT_WIDTH = bsb_pkg::QUAT_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    valid,
	input  logic [2*QUAT_WIDTH:0]   n,
	input  logic [2*QUAT_WIDTH:0]   mabs [bsb_pkg::LANES],
	input  logic                    short_len,
	output logic                    valid_out,
	output logic [QUAT_WIDTH-2:0]   ratio [bsb_pkg::LANES],
	output logic                    small_out
);

	localparam int F  = QUAT_WIDTH - 2;
	localparam int NW = 2 * QUAT_WIDTH + 1;
	localparam int RW = NW + 1;
	localparam int QW = F + 1;
	localparam int NS = F + 2;

	logic          v_s     [NS];
	logic          small_s [NS];
	logic [NW-1:0] n_s     [NS];
	logic [RW-1:0] rem_s   [NS][bsb_pkg::LANES];
	logic [QW-1:0] q_s     [NS][bsb_pkg::LANES];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic          v_in, small_in;
		logic [NW-1:0] n_in;
		logic [RW-1:0] rem_nx [bsb_pkg::LANES];
		logic [QW-1:0] q_nx   [bsb_pkg::LANES];

		if (k == 0) begin : g_first
			assign v_in     = valid;
			assign small_in = short_len;
			assign n_in     = n;
			always_comb begin
				for (int i = 0; i < bsb_pkg::LANES; i++) begin
					if (mabs[i] >= n) begin
						rem_nx[i] = RW'(mabs[i] - n);
						q_nx[i]   = QW'(1);
					end else begin
						rem_nx[i] = RW'(mabs[i]);
						q_nx[i]   = '0;
					end
				end
			end
		end else begin : g_next
			assign v_in     = v_s[k-1];
			assign small_in = small_s[k-1];
			assign n_in     = n_s[k-1];
			always_comb begin
				logic [RW-1:0] r2;
				logic          bit_q;
				for (int i = 0; i < bsb_pkg::LANES; i++) begin
					r2    = rem_s[k-1][i] << 1;
					bit_q = (r2 >= RW'(n_s[k-1]));
					rem_nx[i] = bit_q ? r2 - RW'(n_s[k-1]) : r2;
					if (k == NS - 1) begin
						// round half up
						q_nx[i] = q_s[k-1][i] + QW'(bit_q);
					end else begin
						q_nx[i] = {q_s[k-1][i][QW-2:0], bit_q};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				small_s[k] <= small_in;
				n_s[k]     <= n_in;
				rem_s[k]   <= rem_nx;
				q_s[k]     <= q_nx;
			end
		end
	end

	assign valid_out = v_s[NS-1];
	assign small_out = small_s[NS-1];
	assign ratio     = q_s[NS-1];

endmodule

@@ sv/bsb_extent.sv @@
// Extent and bounds back end: products, row sums, then center -/+ extent with saturation.
// Three register stages; also orders corners for axis-aligned items. Depends on bsb_pkg.
`timescale 1ns / 1ps

module bsb_extent #(
	parameter int COORD_WIDTH = bsb_pkg::COORD_WIDTH_DEF,
	parameter int QUAT_WIDTH  = bsb_pkg::QUAT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid,
	input  logic [QUAT_WIDTH-2:0]         ratio [bsb_pkg::LANES],
	input  logic                          short_len,
	input  bsb_pkg::op_t                  op,
	input  logic signed [COORD_WIDTH-1:0] c [3],
	input  logic signed [COORD_WIDTH-1:0] s [3],
	output logic                          valid_s3,
	output logic signed [COORD_WIDTH-1:0] lo_s3 [3],
	output logic signed [COORD_WIDTH-1:0] hi_s3 [3]
);

	localparam int C  = COORD_WIDTH;
	localparam int F  = QUAT_WIDTH - 2;
	localparam int QW = F + 1;
	localparam int PW = QW + C;
	localparam int SW = PW + 2;
	localparam int EW = C + 2;
	localparam int BW = C + 3;
	localparam logic [QW-1:0] ONE = QW'(1) << F;
	localparam logic signed [C-1:0] MAXV = {1'b0, {(C-1){1'b1}}};
	localparam logic signed [C-1:0] MINV = {1'b1, {(C-1){1'b0}}};

	logic [QW-1:0] r_eff [bsb_pkg::LANES];
	logic [C-1:0]  sabs  [3];

	always_comb begin
		for (int i = 0; i < bsb_pkg::LANES; i++) begin
			if (short_len) begin
				r_eff[i] = (i % 4 == 0) ? ONE : '0;
			end else begin
				r_eff[i] = ratio[i];
			end
		end
		for (int j = 0; j < 3; j++) begin
			sabs[j] = s[j][C-1] ? C'(-s[j]) : C'(s[j]);
		end
	end

	// stage 1: nine products
	logic                valid_s1;
	bsb_pkg::op_t        op_s1;
	logic signed [C-1:0] c_s1 [3];
	logic signed [C-1:0] s_s1 [3];
	logic [PW-1:0]       p_s1 [bsb_pkg::LANES];

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= op;
			c_s1  <= c;
			s_s1  <= s;
			for (int i = 0; i < bsb_pkg::LANES; i++) begin
				p_s1[i] <= PW'(r_eff[i]) * PW'(sabs[i % 3]);
			end
		end
	end

	// stage 2: row sums, rounded
	logic                valid_s2;
	bsb_pkg::op_t        op_s2;
	logic signed [C-1:0] c_s2 [3];
	logic signed [C-1:0] s_s2 [3];
	logic [EW-1:0]       e_s2 [3];

	always_ff @(posedge clk) begin
		logic [SW-1:0] sum;
		if (en) begin
			op_s2 <= op_s1;
			c_s2  <= c_s1;
			s_s2  <= s_s1;
			for (int i = 0; i < 3; i++) begin
				sum = SW'(p_s1[3*i]) + SW'(p_s1[3*i+1]) + SW'(p_s1[3*i+2])
					+ (SW'(1) << F);
				e_s2[i] <= sum[SW-1:F+1];
			end
		end
	end

	// stage 3: bounds
	always_ff @(posedge clk) begin
		logic signed [BW-1:0] dn, up;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dn = BW'(c_s2[i]) - $signed({1'b0, e_s2[i]});
				up = BW'(c_s2[i]) + $signed({1'b0, e_s2[i]});
				if (op_s2 == bsb_pkg::OP_AABB) begin
					lo_s3[i] <= (c_s2[i] < s_s2[i]) ? c_s2[i] : s_s2[i];
					hi_s3[i] <= (c_s2[i] < s_s2[i]) ? s_s2[i] : c_s2[i];
				end else begin
					if ((&dn[BW-1:C-1]) || !(|dn[BW-1:C-1])) begin
						lo_s3[i] <= dn[C-1:0];
					end else begin
						lo_s3[i] <= dn[BW-1] ? MINV : MAXV;
					end
					if ((&up[BW-1:C-1]) || !(|up[BW-1:C-1])) begin
						hi_s3[i] <= up[C-1:0];
					end else begin
						hi_s3[i] <= up[BW-1] ? MINV : MAXV;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

endmodule

@@ sv/box_shape_bounds.sv @@
// box_shape_bounds: axis-aligned bounds of one box per item.
// Stages: quaternion stages (2), the one-bit-per-stage divider (QUAT_WIDTH) and the extent
// stages (3). Throughput: one item per cycle while the skid register is empty; the skid
// register holds one result while m_tready is low, and s_tready stays low while it is full.
// Reset: arst_n clears all valid bits, including the skid register's; no clearing pass.
`timescale 1ns / 1ps

module box_shape_bounds #(
	parameter int COORD_WIDTH = bsb_pkg::COORD_WIDTH_DEF,
	parameter int QUAT_WIDTH  = bsb_pkg::QUAT_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// center_x, center_y, center_z, size_x, size_y, size_z, quat_x, quat_y, quat_z, quat_w
	input  logic [((6*COORD_WIDTH+4*QUAT_WIDTH+7)/8)*8-1:0] s_tdata,
	// op
	input  logic                      s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// min_x, min_y, min_z, max_x, max_y, max_z
	output logic [((6*COORD_WIDTH+7)/8)*8-1:0] m_tdata
);

	localparam int C   = COORD_WIDTH;
	localparam int Q   = QUAT_WIDTH;
	localparam int OW  = ((6*C+7)/8)*8;
	localparam int DL  = Q + 2;

	logic en;
	logic skid_valid_q;

	assign en       = ~skid_valid_q;
	assign s_tready = en;

	// quaternion front end
	logic          qv_s2, qsmall_s2;
	logic [2*Q:0]  n_s2;
	logic [2*Q:0]  mabs_s2 [bsb_pkg::LANES];

	bsb_quat #(.QUAT_WIDTH(Q)) u_quat (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid    (s_tvalid),
		.qx       ($signed(s_tdata[6*C +: Q])),
		.qy       ($signed(s_tdata[6*C+Q +: Q])),
		.qz       ($signed(s_tdata[6*C+2*Q +: Q])),
		.qw       ($signed(s_tdata[6*C+3*Q +: Q])),
		.valid_s2 (qv_s2),
		.n_s2     (n_s2),
		.mabs_s2  (mabs_s2),
		.small_s2 (qsmall_s2)
	);

	logic          dv, dsmall;
	logic [Q-2:0]  ratio [bsb_pkg::LANES];

	bsb_div #(.QUAT_WIDTH(Q)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid     (qv_s2),
		.n         (n_s2),
		.mabs      (mabs_s2),
		.short_len (qsmall_s2),
		.valid_out (dv),
		.ratio     (ratio),
		.small_out (dsmall)
	);

	// hold op, centers and sizes alongside the front end and divider
	bsb_pkg::op_t        op_s [DL];
	logic signed [C-1:0] c_s  [DL][3];
	logic signed [C-1:0] s_s  [DL][3];

	always_ff @(posedge clk) begin
		if (en) begin
			op_s[0] <= bsb_pkg::op_t'(s_tuser);
			for (int j = 0; j < 3; j++) begin
				c_s[0][j] <= $signed(s_tdata[j*C +: C]);
				s_s[0][j] <= $signed(s_tdata[(3+j)*C +: C]);
			end
			for (int k = 1; k < DL; k++) begin
				op_s[k] <= op_s[k-1];
				c_s[k]  <= c_s[k-1];
				s_s[k]  <= s_s[k-1];
			end
		end
	end

	logic                ev_s3;
	logic signed [C-1:0] lo_s3 [3];
	logic signed [C-1:0] hi_s3 [3];

	bsb_extent #(.COORD_WIDTH(C), .QUAT_WIDTH(Q)) u_extent (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid     (dv),
		.ratio     (ratio),
		.short_len (dsmall),
		.op        (op_s[DL-1]),
		.c         (c_s[DL-1]),
		.s         (s_s[DL-1]),
		.valid_s3  (ev_s3),
		.lo_s3     (lo_s3),
		.hi_s3     (hi_s3)
	);

	logic [6*C-1:0] res_c;
	logic [6*C-1:0] skid_q;

	assign res_c = {hi_s3[2], hi_s3[1], hi_s3[0], lo_s3[2], lo_s3[1], lo_s3[0]};

	// park the last stage's item when the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_tready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (ev_s3 && !m_tready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_valid_q && ev_s3 && !m_tready) begin
			skid_q <= res_c;
		end
	end

	assign m_tvalid = skid_valid_q | ev_s3;
	assign m_tdata  = OW'(skid_valid_q ? skid_q : res_c);

endmodule
